>>> hdl/apid_pkg.sv
package apid_pkg;

  localparam int ChanW     = 3;
  localparam int AngleW    = 32;
  localparam int GainW     = 16;
  localparam int ThrW      = 16;
  localparam int IlimW     = 16;
  localparam int OlimW     = 15;
  localparam int ErrW      = AngleW + 1;
  localparam int DiffW     = ErrW + 1;
  localparam int IntW      = IlimW + 1;
  localparam int IntAccW   = ErrW + 1;
  localparam int PProdW    = GainW + ErrW;
  localparam int IProdW    = GainW + IntW;
  localparam int DProdW    = GainW + DiffW;
  localparam int SumW      = DProdW + 2;
  localparam int DriveW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int GainFracBits = 8;

  localparam logic [ThrW-1:0]  SepThrReset  = 16'd200;
  localparam logic [IlimW-1:0] IntLimReset  = 16'd2000;
  localparam logic [OlimW-1:0] OutLimReset  = 15'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_SEP_THR    = 3'd3,
    REG_INT_LIMIT  = 3'd4,
    REG_OUT_LIMIT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic [ThrW-1:0]         sep_thr;
    logic [IlimW-1:0]        int_limit;
    logic [OlimW-1:0]        out_limit;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0]        chan;
    logic signed [ErrW-1:0]  err;
    logic signed [IntW-1:0]  integ;
    logic signed [DiffW-1:0] diff;
  } err_word_t;

  typedef struct packed {
    logic [ChanW-1:0]         chan;
    logic signed [PProdW-1:0] p_prod;
    logic signed [IProdW-1:0] i_prod;
    logic signed [DProdW-1:0] d_prod;
  } prod_word_t;

  typedef struct packed {
    logic [ChanW-1:0]         chan;
    logic                     sat;
    logic signed [DriveW-1:0] drive;
  } result_t;

endpackage

>>> hdl/angle_pid_integral_separation.sv
// Per-channel positional angle PID with integral separation and clamp.
// Input stream: s_axis_tdata carries target and measured angle, s_axis_tuser
// the channel. Each word updates that channel's integral and previous error
// and yields exactly one result word on the master stream: drive value in
// m_axis_tdata, saturation flag and channel echo in m_axis_tuser.
// Gains and limits are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while no word is in flight, which the block does not
// enforce. Writes to an unused index are dropped. The pipeline has four register
// stages (input, error/integral, products, saturate). It takes one word per cycle
// while the receiver is not stalling; the channel state is read and rewritten in
// the single cycle an item leaves the input register, so consecutive words on the
// same channel need no spacing.
// Reset clears all channel integrals and previous errors to zero, empties the
// pipeline and loads the default gains (0) and limits (200, 2000, 1000).
// A stalled receiver holds the result word; each stage keeps accepting until
// it fills, so s_axis_tready drops only once all four stages are occupied.
module angle_pid_integral_separation #(
  parameter int CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // setpoint_angle, measured_angle
  input  logic [7:0]                      s_axis_tuser,  // channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // drive_value
  output logic [7:0]                      m_axis_tuser,  // saturated, out_channel
  input  logic                            cfg_we_i,
  input  logic [apid_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [apid_pkg::CfgDataW-1:0]   cfg_data_i
);
  import apid_pkg::*;

  cfg_t       cfg_q;
  err_word_t  err_word;
  prod_word_t prod_word;
  result_t    res;
  logic       v_err, r_err, v_prod, r_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= '0;
      cfg_q.integ_gain <= '0;
      cfg_q.deriv_gain <= '0;
      cfg_q.sep_thr    <= SepThrReset;
      cfg_q.int_limit  <= IntLimReset;
      cfg_q.out_limit  <= OutLimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data_i;
        REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data_i;
        REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data_i;
        REG_SEP_THR:    cfg_q.sep_thr    <= cfg_data_i;
        REG_INT_LIMIT:  cfg_q.int_limit  <= cfg_data_i;
        REG_OUT_LIMIT:  cfg_q.out_limit  <= cfg_data_i[OlimW-1:0];
        default: ;
      endcase
    end
  end

  apid_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_chan_i     (s_axis_tuser[ChanW-1:0]),
    .in_target_i   (s_axis_tdata[AngleW-1:0]),
    .in_measured_i (s_axis_tdata[2*AngleW-1:AngleW]),
    .cfg_i         (cfg_q),
    .out_valid_o   (v_err),
    .out_ready_i   (r_err),
    .out_o         (err_word)
  );

  apid_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_err),
    .in_ready_o  (r_err),
    .in_i        (err_word),
    .cfg_i       (cfg_q),
    .out_valid_o (v_prod),
    .out_ready_i (r_prod),
    .out_o       (prod_word)
  );

  apid_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_prod),
    .in_ready_o  (r_prod),
    .in_i        (prod_word),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = res.drive;
  assign m_axis_tuser = {4'b0000, res.chan, res.sat};

endmodule

>>> hdl/apid_front.sv
module apid_front #(
  parameter int CHANNELS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [apid_pkg::ChanW-1:0]        in_chan_i,
  input  logic signed [apid_pkg::AngleW-1:0] in_target_i,
  input  logic signed [apid_pkg::AngleW-1:0] in_measured_i,
  input  apid_pkg::cfg_t                    cfg_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output apid_pkg::err_word_t               out_o
);
  import apid_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ModW = (IdxW > ChanW) ? IdxW : ChanW;

  logic                     v1_q, v2_q;
  logic [ChanW-1:0]         chan_q;
  logic signed [AngleW-1:0] tgt_q, meas_q;
  err_word_t                word_q;
  logic                     rdy1, rdy2, adv;

  logic signed [IntW-1:0]  integ_q [CHANNELS];
  logic signed [ErrW-1:0]  prev_q  [CHANNELS];

  logic [ModW-1:0]          mod_tmp;
  logic [IdxW-1:0]          idx;
  logic signed [ErrW-1:0]   err;
  logic [ErrW-1:0]          mag;
  logic signed [IntAccW-1:0] acc, lim_pos, lim_neg;
  logic signed [IntW-1:0]   integ_new;
  logic signed [DiffW-1:0]  diff;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign adv        = v1_q && rdy2;
  assign in_ready_o = rdy1;
  assign out_valid_o = v2_q;
  assign out_o      = word_q;

  // fold the channel number onto the state entries
  always_comb begin
    mod_tmp = ModW'(chan_q);
    for (int k = 0; k < (1 << ChanW); k++) begin
      if ({1'b0, mod_tmp} >= (ModW+1)'(CHANNELS)) begin
        mod_tmp = mod_tmp - ModW'(CHANNELS);
      end
    end
    idx = mod_tmp[IdxW-1:0];
  end

  always_comb begin
    err     = ErrW'(tgt_q) - ErrW'(meas_q);
    mag     = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
    lim_pos = IntAccW'(cfg_i.int_limit);
    lim_neg = -lim_pos;
    acc     = IntAccW'(integ_q[idx]);
    if (mag <= ErrW'(cfg_i.sep_thr)) begin
      acc = acc + IntAccW'(err);
    end
    if (acc > lim_pos) begin
      acc = lim_pos;
    end else if (acc < lim_neg) begin
      acc = lim_neg;
    end
    integ_new = acc[IntW-1:0];
    diff      = DiffW'(err) - DiffW'(prev_q[idx]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        integ_q[k] <= '0;
        prev_q[k]  <= '0;
      end
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (adv) begin
        integ_q[idx] <= integ_new;
        prev_q[idx]  <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      chan_q <= in_chan_i;
      tgt_q  <= in_target_i;
      meas_q <= in_measured_i;
    end
    if (adv) begin
      word_q.chan  <= chan_q;
      word_q.err   <= err;
      word_q.integ <= integ_new;
      word_q.diff  <= diff;
    end
  end

endmodule

>>> hdl/apid_mult.sv
module apid_mult (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  apid_pkg::err_word_t  in_i,
  input  apid_pkg::cfg_t       cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output apid_pkg::prod_word_t out_o
);
  import apid_pkg::*;

  logic       v_q;
  prod_word_t word_q;
  logic       rdy;

  assign rdy         = !v_q || out_ready_i;
  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign out_o       = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      word_q.chan   <= in_i.chan;
      word_q.p_prod <= PProdW'(cfg_i.prop_gain) * PProdW'(in_i.err);
      word_q.i_prod <= IProdW'(cfg_i.integ_gain) * IProdW'(in_i.integ);
      word_q.d_prod <= DProdW'(cfg_i.deriv_gain) * DProdW'(in_i.diff);
    end
  end

endmodule

>>> hdl/apid_sat.sv
module apid_sat (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  apid_pkg::prod_word_t in_i,
  input  apid_pkg::cfg_t       cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output apid_pkg::result_t    out_o
);
  import apid_pkg::*;

  logic                   v_q;
  result_t                res_q;
  logic                   rdy;
  logic signed [SumW-1:0] p_term, i_term, d_term, sum, lim_pos, lim_neg;
  result_t                res_d;

  assign rdy         = !v_q || out_ready_i;
  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign out_o       = res_q;

  always_comb begin
    p_term  = SumW'(in_i.p_prod >>> GainFracBits);
    i_term  = SumW'(in_i.i_prod >>> GainFracBits);
    d_term  = SumW'(in_i.d_prod >>> GainFracBits);
    sum     = p_term + i_term + d_term;
    lim_pos = SumW'(cfg_i.out_limit);
    lim_neg = -lim_pos;
    res_d.chan = in_i.chan;
    if (sum > lim_pos) begin
      res_d.drive = DriveW'(cfg_i.out_limit);
      res_d.sat   = 1'b1;
    end else if (sum < lim_neg) begin
      res_d.drive = lim_neg[DriveW-1:0];
      res_d.sat   = 1'b1;
    end else begin
      res_d.drive = sum[DriveW-1:0];
      res_d.sat   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      res_q <= res_d;
    end
  end

endmodule

>>> hdl/apid_checker.sv
module apid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // back-pressure only once the output is full and stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 16'h8000)
    else $error("drive value outside the symmetric range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[7:4] == 4'b0000)
    else $error("unused user bits set");

endmodule

bind angle_pid_integral_separation apid_checker u_apid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/apid_checker.sv
module apid_scoreboard
  import apid_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // setpoint_angle, measured_angle
  input  logic [7:0]          s_axis_tuser,  // channel
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,  // drive_value
  input  logic [7:0]          m_axis_tuser,  // saturated, out_channel
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                    cfg_q;
  logic signed [IntW-1:0]  integ_mem    [CHANNELS];
  logic signed [ErrW-1:0]  prev_err_mem [CHANNELS];
  result_t                 drive_q [$];
  result_t                 got;
  result_t                 want;

  function automatic result_t pid_step(input logic [ChanW-1:0]         chan,
                                       input logic signed [AngleW-1:0] tgt,
                                       input logic signed [AngleW-1:0] meas);
    int unsigned idx;
    longint      err;
    longint      mag;
    longint      acc;
    longint      lim;
    longint      p_term;
    longint      i_term;
    longint      d_term;
    longint      sum;
    longint      olim;
    result_t     r;
    idx = chan % CHANNELS;
    err = longint'(tgt) - longint'(meas);
    mag = (err < 0) ? -err : err;
    acc = integ_mem[idx];
    if (mag <= longint'(cfg_q.sep_thr)) acc = acc + err;
    lim = longint'(cfg_q.int_limit);
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    p_term = (longint'($signed(cfg_q.prop_gain)) * err) >>> GainFracBits;
    i_term = (longint'($signed(cfg_q.integ_gain)) * acc) >>> GainFracBits;
    d_term = (longint'($signed(cfg_q.deriv_gain)) * (err - longint'(prev_err_mem[idx])))
             >>> GainFracBits;
    integ_mem[idx]    = acc[IntW-1:0];
    prev_err_mem[idx] = err[ErrW-1:0];
    sum  = p_term + i_term + d_term;
    olim = longint'(cfg_q.out_limit);
    r.chan  = chan;
    r.sat   = 1'b0;
    r.drive = sum[DriveW-1:0];
    if (sum > olim) begin
      r.drive = olim[DriveW-1:0];
      r.sat   = 1'b1;
    end else if (sum < -olim) begin
      r.drive = DriveW'(-olim);
      r.sat   = 1'b1;
    end
    return r;
  endfunction

  task automatic note_fail(input string what);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  = '0;
      cfg_q.integ_gain = '0;
      cfg_q.deriv_gain = '0;
      cfg_q.sep_thr    = SepThrReset;
      cfg_q.int_limit  = IntLimReset;
      cfg_q.out_limit  = OutLimReset;
      for (int c = 0; c < CHANNELS; c++) begin
        integ_mem[c]    = '0;
        prev_err_mem[c] = '0;
      end
      drive_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:  cfg_q.prop_gain  = cfg_data_i;
          REG_INTEG_GAIN: cfg_q.integ_gain = cfg_data_i;
          REG_DERIV_GAIN: cfg_q.deriv_gain = cfg_data_i;
          REG_SEP_THR:    cfg_q.sep_thr    = cfg_data_i;
          REG_INT_LIMIT:  cfg_q.int_limit  = cfg_data_i;
          REG_OUT_LIMIT:  cfg_q.out_limit  = cfg_data_i[OlimW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive = m_axis_tdata;
        got.sat   = m_axis_tuser[0];
        got.chan  = m_axis_tuser[ChanW:1];
        if (drive_q.size() == 0) begin
          note_fail($sformatf("unexpected word: drive %0d sat %0b chan %0d",
                              $signed(got.drive), got.sat, got.chan));
        end else begin
          want = drive_q.pop_front();
          if (got.drive !== want.drive || got.sat !== want.sat || got.chan !== want.chan) begin
            note_fail($sformatf({"mismatch: drive exp %0d got %0d, sat exp %0b got %0b, ",
                                 "chan exp %0d got %0d"},
                                $signed(want.drive), $signed(got.drive), want.sat, got.sat,
                                want.chan, got.chan));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        drive_q.push_back(pid_step(s_axis_tuser[ChanW-1:0], s_axis_tdata[AngleW-1:0],
                                   s_axis_tdata[2*AngleW-1:AngleW]));
      end
      pending_o = drive_q.size();
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apid_pkg::*;

  localparam int CHANNELS        = 8;
  localparam int RAND_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 95;
  localparam int CYCLE_LIMIT     = 500000;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [AngleW-1:0]  ANGLE_MAX    = 32'h7fff_ffff;
  localparam logic [AngleW-1:0]  ANGLE_MIN    = 32'h8000_0000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;  // setpoint_angle, measured_angle
  logic [7:0]          s_axis_tuser  = '0;  // channel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // drive_value
  logic [7:0]          m_axis_tuser;        // saturated, out_channel
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  logic                tx_steady = 1'b0;
  logic                rx_steady = 1'b0;
  logic [ThrW-1:0]     sep_now   = SepThrReset;
  int                  fail_cnt;
  int                  pending;

  angle_pid_integral_separation #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  apid_scoreboard #(
    .CHANNELS(CHANNELS)
  ) u_chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    forever #4ns clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL angle_pid_integral_separation");
    $finish;
  end

  function automatic int draw_wait(input logic steady);
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return GainW'($urandom);
    return GainW'($urandom_range(0, 1024) - 512);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_SEP_THR) sep_now = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [ChanW-1:0]  chan,
                           input logic [AngleW-1:0] tgt,
                           input logic [AngleW-1:0] meas);
    int gap;
    gap = draw_wait(tx_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    s_axis_tuser  <= 8'(chan);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // hold off until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_cfg();
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_SEP_THR, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 400)));
    write_reg(REG_INT_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 6000)));
    write_reg(REG_OUT_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                             : {1'($urandom), 15'($urandom_range(0, 3000))});
  endtask

  // mostly errors around the separation threshold, some wide-open angles
  task automatic random_word();
    logic [AngleW-1:0] meas;
    logic [AngleW-1:0] tgt;
    int                span;
    int                kind;
    int                delta;
    span  = int'(sep_now) + 2;
    meas  = $urandom;
    kind  = $urandom_range(0, 9);
    delta = 0;
    if (kind < 7) begin
      delta = int'($urandom_range(0, 2 * span)) - span;
    end else if (kind == 7) begin
      delta = int'(sep_now) + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) delta = -delta;
    end
    if (kind < 8) tgt = meas + AngleW'(delta);
    else tgt = $urandom;
    send_word(ChanW'($urandom_range(0, CHANNELS - 1)), tgt, meas);
  endtask

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_wait(rx_steady);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    int ph;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // proportional only, reset limits: exact limit and one past it
    write_reg(REG_PROP_GAIN, 16'd256);
    send_word(3'd3, 32'd1000, 32'd0);
    send_word(3'd3, 32'd1001, 32'd0);
    send_word(3'd3, -32'sd1000, 32'd0);
    send_word(3'd3, 32'd0, 32'd1001);
    send_word(3'd7, 32'd5, 32'd5);
    send_word(3'd0, ANGLE_MIN, ANGLE_MIN);
    wait_drained();

    // integral only: accumulate at the threshold, skip beyond it
    write_reg(REG_PROP_GAIN, 16'd0);
    write_reg(REG_INTEG_GAIN, 16'd256);
    send_word(3'd4, 32'd200, 32'd0);
    send_word(3'd4, 32'd0, 32'd201);
    send_word(3'd4, -32'sd50, 32'd150);
    wait_drained();

    // extreme gains, wide threshold, tight integral clamp
    write_reg(REG_PROP_GAIN, 16'h7fff);
    write_reg(REG_INTEG_GAIN, 16'h8000);
    write_reg(REG_DERIV_GAIN, 16'h8000);
    write_reg(REG_SEP_THR, 16'hffff);
    write_reg(REG_INT_LIMIT, 16'd300);
    write_reg(REG_OUT_LIMIT, 16'h7fff);
    send_word(3'd5, ANGLE_MAX, ANGLE_MIN);
    send_word(3'd5, ANGLE_MIN, ANGLE_MAX);
    send_word(3'd5, 32'd250, 32'd0);
    send_word(3'd5, 32'd250, 32'd0);
    send_word(3'd5, 32'd0, 32'd65535);
    send_word(3'd6, 32'd0, 32'd0);
    wait_drained();

    // zero limits, floor rounding of small negative terms, dropped spare writes
    write_reg(REG_PROP_GAIN, 16'd1);
    write_reg(REG_INTEG_GAIN, 16'd0);
    write_reg(REG_DERIV_GAIN, 16'd0);
    write_reg(REG_SEP_THR, 16'd0);
    write_reg(REG_INT_LIMIT, 16'd0);
    write_reg(REG_OUT_LIMIT, 16'h8000);
    write_reg(REG_SPARE_LO, 16'hffff);
    write_reg(REG_SPARE_HI, 16'h1234);
    send_word(3'd2, 32'd0, 32'd0);
    send_word(3'd2, 32'd300, 32'd0);
    send_word(3'd2, 32'd0, 32'd300);
    send_word(3'd2, 32'd0, 32'd1);
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PROP_GAIN, 16'h7fff);
          write_reg(REG_INTEG_GAIN, 16'h8000);
          write_reg(REG_DERIV_GAIN, 16'h7fff);
          write_reg(REG_SEP_THR, 16'hffff);
          write_reg(REG_INT_LIMIT, 16'hffff);
          write_reg(REG_OUT_LIMIT, 16'h7fff);
        end
        1: begin
          write_reg(REG_PROP_GAIN, 16'h8000);
          write_reg(REG_INTEG_GAIN, 16'h7fff);
          write_reg(REG_DERIV_GAIN, 16'h8000);
          write_reg(REG_SEP_THR, 16'd0);
          write_reg(REG_INT_LIMIT, 16'd0);
          write_reg(REG_OUT_LIMIT, 16'd0);
        end
        default: random_cfg();
      endcase
      tx_steady = (ph == 2 || ph == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
      rx_steady = (ph == 2) ? 1'b1 : (ph == 3) ? 1'b0 : ($urandom_range(0, 3) == 0);
      repeat (WORDS_PER_PHASE) random_word();
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) $display("PASS angle_pid_integral_separation");
    else $display("FAIL angle_pid_integral_separation");
    $finish;
  end

endmodule

>>> files.f
hdl/apid_pkg.sv
hdl/apid_front.sv
hdl/apid_mult.sv
hdl/apid_sat.sv
hdl/angle_pid_integral_separation.sv
hdl/apid_checker.sv
verif/apid_checker.sv
verif/tb.sv
